// ----- design/rpf_pkg.sv -----
// ----------------------------------------------------------------------------
// rpf_pkg
// Shared types, constants and CRC helper for the packet framer with CRC-16.
// ----------------------------------------------------------------------------
`default_nettype none

package rpf_pkg;

  localparam int RPF_QUEUE_DEPTH = 2;

  localparam int IDX_W = 5;

  // byte positions within the frame
  localparam logic [IDX_W-1:0] POS_LEAD_FIRST = 5'd0;
  localparam logic [IDX_W-1:0] POS_LEAD_LAST  = 5'd7;
  localparam logic [IDX_W-1:0] POS_ID_HI      = 5'd8;
  localparam logic [IDX_W-1:0] POS_ID_MID     = 5'd9;
  localparam logic [IDX_W-1:0] POS_ID_LO      = 5'd10;
  localparam logic [IDX_W-1:0] POS_SEP        = 5'd11;
  localparam logic [IDX_W-1:0] POS_SEQ        = 5'd12;
  localparam logic [IDX_W-1:0] POS_CMD_HI     = 5'd13;
  localparam logic [IDX_W-1:0] POS_CMD_LO     = 5'd14;
  localparam logic [IDX_W-1:0] POS_CRC_HI     = 5'd15;
  localparam logic [IDX_W-1:0] POS_CRC_LO     = 5'd16;

  localparam logic [7:0]  SEP_BYTE = 8'hFF;
  localparam logic [15:0] CRC_INIT = 16'hFFFE;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef struct packed {
    logic [23:0] remote_id;
    logic [15:0] command_code;
    logic [7:0]  sequence_count;
  } rpf_req_t;

  function automatic logic [7:0] lead_byte(input logic [2:0] pos);
    logic [7:0] b;
    case (pos)
      3'd0:    b = 8'h53;
      3'd1:    b = 8'h39;
      3'd2:    b = 8'h14;
      3'd3:    b = 8'hDD;
      3'd4:    b = 8'h1C;
      3'd5:    b = 8'h49;
      3'd6:    b = 8'h34;
      3'd7:    b = 8'h12;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // msb-first crc over one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- design/rpf_req_queue.sv -----
// ----------------------------------------------------------------------------
// rpf_req_queue
// Front side: accepts requests and holds them in a short queue for the framer.
// ----------------------------------------------------------------------------
`default_nettype none

module rpf_req_queue
  import rpf_pkg::*;
#(
  parameter int DEPTH = RPF_QUEUE_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire rpf_req_t in_req,
  output logic          q_valid,
  input  wire logic     q_ready,
  output rpf_req_t      q_req
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  rpf_req_t         mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_ready = (count != CNT_FULL);
  assign q_valid  = (count != '0);
  assign q_req    = mem[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/rpf_framer.sv -----
// ----------------------------------------------------------------------------
// rpf_framer
// Back side: serializes one request into a 17-byte frame with running CRC.
// ----------------------------------------------------------------------------
`default_nettype none

module rpf_framer
  import rpf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     q_valid,
  output logic          q_ready,
  input  wire rpf_req_t q_req,
  output logic          out_valid,
  input  wire logic     out_ready,
  output logic [7:0]    packet_byte,
  output logic          final_byte
);

  logic             act;
  logic [IDX_W-1:0] idx;
  rpf_req_t         req;
  logic [15:0]      crc;
  logic             load;
  logic             take;
  logic [7:0]       cur_byte;
  logic [7:0]       first_byte;
  logic [15:0]      first_crc;

  assign load       = !out_valid || out_ready;
  assign take       = load && !act && q_valid;
  assign q_ready    = take;
  assign first_byte = lead_byte(3'd0);
  assign first_crc  = crc16_byte(CRC_INIT, first_byte);

  always_comb begin
    case (idx)
      POS_ID_HI:  cur_byte = req.remote_id[23:16];
      POS_ID_MID: cur_byte = req.remote_id[15:8];
      POS_ID_LO:  cur_byte = req.remote_id[7:0];
      POS_SEP:    cur_byte = SEP_BYTE;
      POS_SEQ:    cur_byte = req.sequence_count;
      POS_CMD_HI: cur_byte = req.command_code[15:8];
      POS_CMD_LO: cur_byte = req.command_code[7:0];
      POS_CRC_HI: cur_byte = crc[15:8];
      POS_CRC_LO: cur_byte = crc[7:0];
      default: begin
        if (idx <= POS_LEAD_LAST) begin
          cur_byte = lead_byte(idx[2:0]);
        end else begin
          cur_byte = lead_byte(POS_LEAD_FIRST[2:0]);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act       <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else if (load) begin
      if (act) begin
        out_valid <= 1'b1;
        idx       <= idx + 1'b1;
        if (idx == POS_CRC_LO) begin
          act <= 1'b0;
        end
      end else if (q_valid) begin
        out_valid <= 1'b1;
        act       <= 1'b1;
        idx       <= POS_LEAD_FIRST + 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (act) begin
        packet_byte <= cur_byte;
        final_byte  <= (idx == POS_CRC_LO);
        if (idx < POS_CRC_HI) begin
          crc <= crc16_byte(crc, cur_byte);
        end
      end else if (q_valid) begin
        req         <= q_req;
        packet_byte <= first_byte;
        final_byte  <= 1'b0;
        crc         <= first_crc;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/remote_packet_framer_crc16.sv -----
// ----------------------------------------------------------------------------
// remote_packet_framer_crc16
// Turns a command request into a 17-byte radio packet with a CRC-16 trailer.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries one request: remote_id,
// command_code and sequence_count. Output channel out_valid/out_ready
// carries the packet one byte per item on packet_byte, in transmission
// order; final_byte marks the last byte (the CRC low byte).
// Requests go into a queue of QUEUE_DEPTH entries; the framer pops one,
// emits 17 bytes and folds each byte ahead of the CRC trailer into the CRC.
// A request accepted at the input is written into the queue; when the
// framer is free it pops the request and registers its first byte on
// packet_byte. No new request is popped until the final byte is taken;
// a queued frame starts in the cycle after the final byte is taken.
// Reset empties the queue and drops any frame in flight. When the receiver
// holds out_ready low the byte holds, the framer stalls, and the queue
// keeps accepting until full, then drops in_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module remote_packet_framer_crc16
  import rpf_pkg::*;
#(
  parameter int QUEUE_DEPTH = RPF_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [23:0] remote_id,
  input  wire logic [15:0] command_code,
  input  wire logic [7:0]  sequence_count,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       packet_byte,
  output logic             final_byte
);

  rpf_req_t in_req;
  rpf_req_t q_req;
  logic     q_valid;
  logic     q_ready;

  assign in_req = '{remote_id: remote_id, command_code: command_code,
                    sequence_count: sequence_count};

  rpf_req_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_req  (in_req),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_req   (q_req)
  );

  rpf_framer u_framer (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_req      (q_req),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .packet_byte(packet_byte),
    .final_byte (final_byte)
  );

endmodule

`default_nettype wire

// ----- design/rpf_checker.sv -----
// ----------------------------------------------------------------------------
// rpf_checker
// Port-level checks on the packet framer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rpf_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] packet_byte,
  input wire logic       final_byte
);

  logic [4:0] cnt;
  logic       out_fire;

  assign out_fire = out_valid && out_ready;

  // position of the next byte within its frame
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (out_fire) begin
      cnt <= (cnt == 5'd16) ? 5'd0 : cnt + 5'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(packet_byte) && $stable(final_byte))
    else $error("output item changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_final_pos: assert property (@(posedge clk) disable iff (rst)
    out_fire |-> (final_byte == (cnt == 5'd16)))
    else $error("final byte flag at wrong position");

  a_frame_start: assert property (@(posedge clk) disable iff (rst)
    out_fire && cnt == 5'd0 |-> packet_byte == 8'h53)
    else $error("frame does not open with preamble");

  a_separator: assert property (@(posedge clk) disable iff (rst)
    out_fire && cnt == 5'd11 |-> packet_byte == 8'hFF)
    else $error("separator byte wrong");

endmodule

bind remote_packet_framer_crc16 rpf_checker u_rpf_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .packet_byte(packet_byte),
  .final_byte (final_byte)
);

`default_nettype wire
